[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/oiss_pkg.sv]
// ----------------------------------------------------------------------------
// oiss_pkg
// shared constants and controller/datapath types for the ordered set store
// ----------------------------------------------------------------------------
package oiss_pkg;

  localparam int SET_CAPACITY = 64;
  localparam int VALUE_W      = 32;
  localparam int ACTION_W     = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 7;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the item value
    logic cmp;      // register the per-cell hit vector
    logic add;      // append value at the end
    logic remove;   // drop the hit entry, shift later ones down
    logic clear;    // empty the set
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found;
    logic full;
  } dp_stat_t;

endpackage

[sv/ordered_integer_set_store_unit.sv]
// ----------------------------------------------------------------------------
// ordered_integer_set_store_unit
// insertion-ordered set of distinct 32-bit integers with add/remove/query/clear
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low. every item returns one
// result: done pulses for one cycle with status and count, and the receiver
// cannot hold it off. an item passes these steps in order, and no new item is
// taken until it is through: capture the value, register the match of every
// cell against it in parallel, and apply the add, the shift-down removal or
// the clear. a new item may start in the cycle done is shown.
// count is the member count after the item, low 7 bits. members need no
// clearing after reset: only entries below the count are ever matched.
module ordered_integer_set_store_unit #(
  parameter int SET_CAPACITY = oiss_pkg::SET_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [oiss_pkg::ACTION_W-1:0]       action,
  input  logic signed [oiss_pkg::VALUE_W-1:0] value,
  output logic                                done,
  output logic [oiss_pkg::STATUS_W-1:0]       status,
  output logic [oiss_pkg::COUNT_W-1:0]        count
);
  import oiss_pkg::*;

  // command and status between sequencer and cell row
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decides the outcome from found/full and drives the result strobe
  oiss_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  // cell row: holds the members and the count, count is updated on apply
  oiss_dpath #(
    .CAP (SET_CAPACITY)
  ) u_dpath (
    .clk   (clk),
    .rst   (rst),
    .value (value),
    .cmd   (cmd),
    .stat  (stat),
    .count (count)
  );

endmodule

[sv/oiss_ctrl.sv]
// ----------------------------------------------------------------------------
// oiss_ctrl
// sequencer: capture, compare, apply, and result status
// ----------------------------------------------------------------------------
module oiss_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [oiss_pkg::ACTION_W-1:0]      action,
  input  oiss_pkg::dp_stat_t                 stat,
  output oiss_pkg::dp_cmd_t                  cmd,
  output logic                               busy,
  output logic                               done,
  output logic [oiss_pkg::STATUS_W-1:0]      status
);
  import oiss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [ACTION_W-1:0] action_q;
  logic                done_next;
  logic [STATUS_W-1:0] status_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    done_next   = 1'b0;
    status_next = status;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        case (action_q)
          ACT_ADD: begin
            if (stat.found) begin
              status_next = ST_MISS;
            end else if (stat.full) begin
              status_next = ST_FULL;
            end else begin
              status_next = ST_OK;
              cmd.add     = 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (stat.found) begin
              status_next = ST_OK;
              cmd.remove  = 1'b1;
            end else begin
              status_next = ST_MISS;
            end
          end
          ACT_QUERY: begin
            status_next = stat.found ? ST_OK : ST_MISS;
          end
          default: begin
            status_next = ST_OK;
            cmd.clear   = 1'b1;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action;
    end
    status <= status_next;
  end

  assign busy = (state != S_IDLE);

endmodule

[sv/oiss_dpath.sv]
// ----------------------------------------------------------------------------
// oiss_dpath
// row of member entries with parallel match, append and shift-down removal
// ----------------------------------------------------------------------------
module oiss_dpath #(
  parameter int CAP = oiss_pkg::SET_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [oiss_pkg::VALUE_W-1:0] value,
  input  oiss_pkg::dp_cmd_t                 cmd,
  output oiss_pkg::dp_stat_t                stat,
  output logic [oiss_pkg::COUNT_W-1:0]      count
);
  import oiss_pkg::*;

  localparam int CW = $clog2(CAP + 1);
  localparam int IW = $clog2(CAP);

  logic signed [VALUE_W-1:0] value_q;
  logic [VALUE_W-1:0]        entry    [CAP];
  logic [VALUE_W-1:0]        entry_up [CAP];
  logic [CAP-1:0]            hit, hit_next;
  logic [CW-1:0]             cnt;
  logic [IW-1:0]             hit_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_q <= value;
    end
    if (cmd.cmp) begin
      hit <= hit_next;
    end
  end

  // one-hot hit vector to position; entries are distinct so at most one bit
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAP; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  for (genvar g = 0; g < CAP; g++) begin : g_entry
    assign hit_next[g] = (entry[g] == value_q) && (CW'(g) < cnt);

    if (g < CAP - 1) begin : g_up
      assign entry_up[g] = entry[g+1];
    end else begin : g_top
      assign entry_up[g] = entry[g];
    end

    always_ff @(posedge clk) begin
      if (cmd.add && (CW'(g) == cnt)) begin
        entry[g] <= value_q;
      end else if (cmd.remove && (IW'(g) >= hit_idx)) begin
        entry[g] <= entry_up[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clear) begin
      cnt <= '0;
    end else if (cmd.add) begin
      cnt <= cnt + CW'(1);
    end else if (cmd.remove) begin
      cnt <= cnt - CW'(1);
    end
  end

  assign stat.found = |hit;
  assign stat.full  = (cnt >= CW'(CAP));
  assign count      = COUNT_W'(cnt);

endmodule

[sv/oiss_checker.sv]
// ----------------------------------------------------------------------------
// oiss_checker
// port-level checks on the ordered set store, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oiss_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [oiss_pkg::ACTION_W-1:0]       action,
  input logic                                done,
  input logic [oiss_pkg::STATUS_W-1:0]       status,
  input logic [oiss_pkg::COUNT_W-1:0]        count
);
  import oiss_pkg::*;

  logic taken;
  logic clear_taken;
  logic clear_ok;
  assign taken       = start && !busy;
  assign clear_taken = taken && (action == ACT_CLEAR);
  assign clear_ok    = (count == '0) && (status == ST_OK);

  `ASSERT_CLK_RST(a_taken_busy, clk, rst, taken |=> busy, "item taken but not busy")
  `ASSERT_CLK_RST(a_result_lat, clk, rst, taken |-> ##3 done, "result missing after item")
  `ASSERT_CLK_RST(a_clear_res, clk, rst, clear_taken |-> ##3 clear_ok, "clear result wrong")
  `ASSERT_CLK_RST(a_idle_count, clk, rst, (!busy && !done) |=> $stable(count), "count moved")

endmodule

bind ordered_integer_set_store_unit oiss_checker u_oiss_checker (.*);
